>>> sv/fee_pkg.sv
// Package: types and constants for the flash EEPROM emulation block.
package fee_pkg;

  localparam int EepromBytes = 1024;
  localparam int PageWords = 2048;
  localparam int HwCount = (EepromBytes + 1) / 2;
  localparam int HwIdxW = $clog2(HwCount);
  localparam int PtrW = $clog2(PageWords + 1);
  localparam int WordW = $clog2(PageWords);
  localparam int FlashAw = $clog2(2 * PageWords);
  localparam logic [31:0] FlashErased = 32'hFFFF_FFFF;
  localparam logic [31:0] FlashReceiving = 32'hEEEE_EEEE;
  localparam logic [31:0] FlashValid = 32'h0000_0000;

  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusRange = 2'd1;
  localparam logic [1:0] StatusSame = 2'd2;

  typedef struct packed {
    logic mode;
    logic [15:0] byte_address;
    logic [7:0] write_data;
    logic last_in_block;
  } in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [1:0] status;
    logic page_swapped;
    logic active_page_out;
  } out_t;

  typedef struct packed {
    logic in_range;
    logic mode;
    logic [HwIdxW-1:0] idx;
    logic odd;
    logic [7:0] wdata;
  } cmd_t;

endpackage

>>> sv/fee_ram.sv
// Generic single-port RAM with registered read.
module fee_ram #(
  parameter int Width = 16,
  parameter int Depth = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

>>> sv/fee_front.sv
// Front end: accept transfers, classify and queue commands.
module fee_front (
  input  logic          clk,
  input  logic          rst,
  input  fee_pkg::in_t  in_data,
  input  logic          in_valid,
  output logic          in_ready,
  output fee_pkg::cmd_t cmd,
  output logic          cmd_valid,
  input  logic          cmd_ready
);
  import fee_pkg::*;
  cmd_t q [2];
  logic wp, rp;
  logic [1:0] cnt;
  logic push, pop;
  cmd_t c;

  assign in_ready = cnt != 2'd2;
  assign cmd_valid = cnt != 2'd0;
  assign cmd = q[rp];
  assign push = in_valid && in_ready;
  assign pop = cmd_valid && cmd_ready;

  always_comb begin
    c.in_range = {16'd0, in_data.byte_address} < 32'(EepromBytes);
    c.mode = in_data.mode;
    c.idx = in_data.byte_address[HwIdxW:1];
    c.odd = in_data.byte_address[0];
    c.wdata = in_data.write_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        q[wp] <= c;
        wp <= ~wp;
      end
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

>>> sv/fee_back.sv
// Back end: mirror lookup, record append and page transfer sequencer.
module fee_back (
  input  logic          clk,
  input  logic          rst,
  input  fee_pkg::cmd_t cmd,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  output fee_pkg::out_t out_data,
  output logic          out_valid,
  input  logic          out_ready
);
  import fee_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LOOK, S_ERASE, S_HDR, S_REC, S_CRD, S_CWAIT, S_COPY,
    S_ERASE_OLD, S_VALID
  } state_t;

  state_t state;
  cmd_t cur;
  logic [HwIdxW:0] ci;
  logic [WordW-1:0] ew;
  logic active_page;
  logic [PtrW-1:0] append_pointer, ptr;
  logic [31:0] rec;

  logic mwe;
  logic [HwIdxW-1:0] maddr;
  logic [15:0] mwdata, mrdata;
  logic fwe;
  logic [FlashAw-1:0] faddr;
  logic [31:0] fwdata, frdata;

  logic [7:0] old_byte;
  logic [15:0] new_hw;
  logic [PtrW-1:0] full_ptr;
  logic look_write;
  out_t look_res;
  assign full_ptr = PtrW'(PageWords);
  assign old_byte = cur.odd ? mrdata[15:8] : mrdata[7:0];
  assign new_hw = cur.odd ? {cur.wdata, mrdata[7:0]} : {mrdata[15:8], cur.wdata};
  assign look_write = cur.in_range && cur.mode && old_byte != cur.wdata;

  always_comb begin
    look_res = '0;
    look_res.active_page_out = active_page;
    if (!cur.in_range) begin
      look_res.status = StatusRange;
    end else if (!cur.mode) begin
      look_res.read_data = old_byte;
    end else if (old_byte == cur.wdata) begin
      look_res.status = StatusSame;
    end
  end

  fee_ram #(.Width(16), .Depth(1 << HwIdxW)) u_mirror (
    .clk, .we(mwe), .addr(maddr), .wdata(mwdata), .rdata(mrdata)
  );
  fee_ram #(.Width(32), .Depth(2 * PageWords)) u_flash (
    .clk, .we(fwe), .addr(faddr), .wdata(fwdata), .rdata(frdata)
  );

  assign cmd_ready = state == S_IDLE && !out_valid;

  always_comb begin
    mwe = 1'b0;
    maddr = cmd.idx;
    mwdata = new_hw;
    fwe = 1'b0;
    faddr = '0;
    fwdata = rec;
    unique case (state)
      S_CLEAR: begin
        mwe = 1'b1;
        maddr = ci[HwIdxW-1:0];
        mwdata = '0;
        fwe = 1'b1;
        faddr = FlashAw'(ci) ;
        fwdata = (ci == '0) ? FlashValid : FlashErased;
      end
      S_IDLE: ;
      S_LOOK: begin
        maddr = cur.idx;
        if (look_write) begin
          mwe = 1'b1;
          if (append_pointer != full_ptr) begin
            fwe = 1'b1;
            faddr = {active_page, append_pointer[WordW-1:0]};
            fwdata = {{(16 - HwIdxW){1'b0}}, cur.idx, new_hw};
          end
        end
      end
      S_ERASE: begin
        fwe = 1'b1;
        faddr = {~active_page, ew};
        fwdata = FlashErased;
      end
      S_HDR: begin
        fwe = 1'b1;
        faddr = {~active_page, WordW'(0)};
        fwdata = FlashReceiving;
      end
      S_REC: begin
        fwe = 1'b1;
        faddr = {~active_page, ptr[WordW-1:0]};
        fwdata = rec;
      end
      S_CRD, S_CWAIT: maddr = ci[HwIdxW-1:0];
      S_COPY: begin
        maddr = ci[HwIdxW-1:0];
        if (mrdata != 16'd0 && ptr != full_ptr) begin
          fwe = 1'b1;
          faddr = {~active_page, ptr[WordW-1:0]};
          fwdata = {{(16 - HwIdxW){1'b0}}, ci[HwIdxW-1:0], mrdata};
        end
      end
      S_ERASE_OLD: begin
        fwe = 1'b1;
        faddr = {active_page, ew};
        fwdata = FlashErased;
      end
      S_VALID: begin
        fwe = 1'b1;
        faddr = {~active_page, WordW'(0)};
        fwdata = FlashValid;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      ci <= '0;
      out_valid <= 1'b0;
      active_page <= 1'b0;
      append_pointer <= PtrW'(1);
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          ci <= ci + (HwIdxW + 1)'(1);
          if (ci == (HwIdxW + 1)'((1 << HwIdxW) - 1)) state <= S_IDLE;
        end
        S_IDLE: if (cmd_valid && cmd_ready) begin
          cur <= cmd;
          state <= S_LOOK;
        end
        S_LOOK: begin
          out_data <= look_res;
          if (look_write && append_pointer == full_ptr) begin
            rec <= {{(16 - HwIdxW){1'b0}}, cur.idx, new_hw};
            ew <= '0;
            state <= S_ERASE;
          end else begin
            if (look_write) append_pointer <= append_pointer + PtrW'(1);
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_ERASE: begin
          ew <= ew + WordW'(1);
          if (ew == WordW'(PageWords - 1)) state <= S_HDR;
        end
        S_HDR: begin
          ptr <= PtrW'(1);
          state <= S_REC;
        end
        S_REC: begin
          ptr <= ptr + PtrW'(1);
          ci <= '0;
          state <= S_CRD;
        end
        S_CRD: state <= S_CWAIT;
        S_CWAIT: state <= S_COPY;
        S_COPY: begin
          if (mrdata != 16'd0 && ptr != full_ptr) ptr <= ptr + PtrW'(1);
          ci <= ci + (HwIdxW + 1)'(1);
          if (ci == (HwIdxW + 1)'(HwCount - 1)) begin
            ew <= '0;
            state <= S_ERASE_OLD;
          end else begin
            state <= S_CRD;
          end
        end
        S_ERASE_OLD: begin
          ew <= ew + WordW'(1);
          if (ew == WordW'(PageWords - 1)) state <= S_VALID;
        end
        S_VALID: begin
          active_page <= ~active_page;
          append_pointer <= ptr;
          out_data.page_swapped <= 1'b1;
          out_data.active_page_out <= ~active_page;
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  logic unused;
  assign unused = ^frdata;
endmodule

>>> sv/flash_eeprom_emulation.sv
// Top level: two-page flash EEPROM emulation with a byte interface.
//
// Input channel in_data/in_valid/in_ready carries byte reads and writes;
// output channel out_data/out_valid/out_ready returns one result per item,
// in order. A front stage classifies items into a two-entry queue; the back
// sequencer runs them one at a time against a halfword mirror RAM and a
// flash array RAM, both single-port with registered read.
// The back end takes an item from the queue, looks it up and registers
// the result; it takes the next item only once the result has left, so
// ordinary items never overlap. A write that finds the active page full
// runs a page transfer: erase the other page, header and record, copy of
// every nonzero mirror halfword, erase of the old page and the valid
// header; the channel stalls meanwhile.
// After reset the back end clears the mirror and writes the page 0 header
// and the first flash words, and accepts no item until that is done; page
// 0 starts active. A stalled receiver holds the result and, once the queue
// fills, holds in_ready low.
module flash_eeprom_emulation (
  input  logic          clk,
  input  logic          rst,
  input  fee_pkg::in_t  in_data,
  input  logic          in_valid,
  output logic          in_ready,
  output fee_pkg::out_t out_data,
  output logic          out_valid,
  input  logic          out_ready
);
  import fee_pkg::*;
  cmd_t cmd;
  logic cmd_valid, cmd_ready;

  fee_front u_front (
    .clk, .rst, .in_data, .in_valid, .in_ready, .cmd, .cmd_valid, .cmd_ready
  );
  fee_back u_back (
    .clk, .rst, .cmd, .cmd_valid, .cmd_ready, .out_data, .out_valid, .out_ready
  );

  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.status != 2'd3) else $error("bad status");
  a_swap_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.page_swapped |-> out_data.status == StatusOk)
    else $error("swap with nonzero status");
  a_rd_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != StatusOk |-> out_data.read_data == 8'd0)
    else $error("read data on failed item");
endmodule
